/* design/tts_pkg.sv */
// Shared types and constants for the text terminal with scrolling.
// Holds the command word passed from the front to the back, opcodes and codes.
// No dependencies.
`default_nettype none

package tts_pkg;

  localparam int DEF_COLUMNS = 40;
  localparam int DEF_ROWS    = 30;

  // widths that cover the full parameter range
  localparam int REQ_ROW_W = 6;
  localparam int REQ_COL_W = 7;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_FIRST = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [6:0] BLANK_CODE = 7'h20;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_SETPOS = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_LF,
    CMD_CR,
    CMD_TAB,
    CMD_SETPOS,
    CMD_CLEAR,
    CMD_READ,
    CMD_NONE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [6:0]           code;
    logic [REQ_ROW_W-1:0] row;
    logic [REQ_COL_W-1:0] col;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SWEEP
  } bk_state_e;

endpackage

`default_nettype wire

/* design/tts_front.sv */
// Front end of the text terminal: accepts input words and classifies them.
// Decodes the operation and character, clamps position requests. Uses tts_pkg.
`default_nettype none

module tts_front #(
  parameter int COLUMNS = tts_pkg::DEF_COLUMNS,
  parameter int ROWS    = tts_pkg::DEF_ROWS
) (
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic signed [7:0] row_request_i,
  input  wire logic signed [7:0] col_request_i,
  input  wire logic              q_full_i,
  input  wire logic              init_busy_i,
  output logic                   push_o,
  output tts_pkg::cmd_t          cmd_o
);
  import tts_pkg::*;

  logic [7:0] row_raw, col_raw, row_c, col_c;

  assign row_raw = row_request_i;
  assign col_raw = col_request_i;

  always_comb begin
    if (row_raw[7]) begin
      row_c = '0;
    end else if (row_raw >= 8'(ROWS)) begin
      row_c = 8'(ROWS - 1);
    end else begin
      row_c = row_raw;
    end
    if (col_raw[7]) begin
      col_c = '0;
    end else if (col_raw >= 8'(COLUMNS)) begin
      col_c = 8'(COLUMNS - 1);
    end else begin
      col_c = col_raw;
    end
  end

  always_comb begin
    cmd_o.code = char_code_i[6:0];
    cmd_o.row  = REQ_ROW_W'(row_c);
    cmd_o.col  = REQ_COL_W'(col_c);
    unique case (op_e'(operation_i))
      OP_PUT: begin
        if (char_code_i == CH_LF) begin
          cmd_o.kind = CMD_LF;
        end else if (char_code_i == CH_CR) begin
          cmd_o.kind = CMD_CR;
        end else if (char_code_i == CH_TAB) begin
          cmd_o.kind = CMD_TAB;
        end else if (char_code_i >= CH_FIRST && char_code_i < CH_DEL) begin
          cmd_o.kind = CMD_PRINT;
        end else begin
          cmd_o.kind = CMD_NONE;
        end
      end
      OP_SETPOS: cmd_o.kind = CMD_SETPOS;
      OP_CLEAR:  cmd_o.kind = CMD_CLEAR;
      OP_READ:   cmd_o.kind = CMD_READ;
      default:   cmd_o.kind = CMD_NONE;
    endcase
  end

  assign in_ready_o = !q_full_i && !init_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

endmodule

`default_nettype wire

/* design/tts_queue.sv */
// Two-entry command queue between the front and back of the text terminal.
// Stores tts_pkg::cmd_t words. Uses tts_pkg.
`default_nettype none

module tts_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tts_pkg::cmd_t cmd_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               valid_o,
  output tts_pkg::cmd_t      cmd_o
);
  import tts_pkg::*;

  cmd_t       entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/tts_back.sv */
// Back end of the text terminal: screen store, cursor, scroll and clear sweeps.
// Executes queued commands and holds the result register. Uses tts_pkg.
`default_nettype none

module tts_back #(
  parameter int COLUMNS = tts_pkg::DEF_COLUMNS,
  parameter int ROWS    = tts_pkg::DEF_ROWS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire tts_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               init_busy_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [4:0]         cursor_row_o,
  output logic [5:0]         cursor_col_o,
  output logic [6:0]         cell_data_o
);
  import tts_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = $clog2(CELLS);

  function automatic logic [AW-1:0] phys_addr(logic [RW-1:0] r, logic [CW-1:0] c,
                                              logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return AW'(s[RW-1:0]) * AW'(COLUMNS) + AW'(c);
  endfunction

  logic [6:0] mem_q [CELLS];
  logic [6:0] rdata_q;

  bk_state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d, base_q, base_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] sweep_addr_q, sweep_addr_d, sweep_end_q, sweep_end_d;
  logic          reply_q, reply_d;
  logic          out_valid_q, out_valid_d;
  logic [4:0]    out_row_q, out_row_d;
  logic [5:0]    out_col_q, out_col_d;
  logic [6:0]    out_cell_q, out_cell_d;

  logic          we, out_load;
  logic [AW-1:0] waddr, raddr, home_addr;
  logic [6:0]    wdata, out_cell_n;
  logic          last_row;
  logic [RW-1:0] base_inc;
  logic [CW:0]   col_inc, col_tab;

  assign last_row  = (row_q == RW'(ROWS - 1));
  assign base_inc  = (base_q == RW'(ROWS - 1)) ? '0 : base_q + RW'(1);
  assign col_inc   = {1'b0, col_q} + (CW+1)'(1);
  assign col_tab   = ({1'b0, col_q} + (CW+1)'(4)) & ~(CW+1)'(3);
  assign home_addr = phys_addr('0, '0, base_q);
  assign raddr     = phys_addr(cmd_i.row[RW-1:0], cmd_i.col[CW-1:0], base_q);

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    base_d       = base_q;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    reply_d      = reply_q;
    pop_o        = 1'b0;
    we           = 1'b0;
    waddr        = sweep_addr_q;
    wdata        = BLANK_CODE;
    out_load     = 1'b0;
    out_cell_n   = '0;

    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && (!out_valid_q || out_ready_i)) begin
          pop_o    = 1'b1;
          out_load = 1'b1;
          unique case (cmd_i.kind) inside
            CMD_PRINT, CMD_LF, CMD_TAB: begin
              if (cmd_i.kind == CMD_PRINT) begin
                we    = 1'b1;
                waddr = phys_addr(row_q, col_q, base_q);
                wdata = cmd_i.code;
              end
              if (cmd_i.kind == CMD_PRINT && col_inc != (CW+1)'(COLUMNS)) begin
                col_d = col_inc[CW-1:0];
              end else if (cmd_i.kind == CMD_TAB && col_tab < (CW+1)'(COLUMNS)) begin
                col_d = col_tab[CW-1:0];
              end else begin
                col_d = '0;
                if (last_row) begin
                  base_d       = base_inc;
                  sweep_addr_d = home_addr;
                  sweep_end_d  = home_addr + AW'(COLUMNS - 1);
                  reply_d      = 1'b1;
                  state_d      = BK_SWEEP;
                  out_load     = 1'b0;
                end else begin
                  row_d = row_q + RW'(1);
                end
              end
            end
            CMD_CR: begin
              col_d = '0;
            end
            CMD_SETPOS: begin
              row_d = cmd_i.row[RW-1:0];
              col_d = cmd_i.col[CW-1:0];
            end
            CMD_CLEAR: begin
              row_d        = '0;
              col_d        = '0;
              base_d       = '0;
              sweep_addr_d = '0;
              sweep_end_d  = AW'(CELLS - 1);
              reply_d      = 1'b1;
              state_d      = BK_SWEEP;
              out_load     = 1'b0;
            end
            CMD_READ: begin
              state_d  = BK_READ;
              out_load = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      BK_READ: begin
        out_load   = 1'b1;
        out_cell_n = rdata_q;
        state_d    = BK_IDLE;
      end
      BK_SWEEP: begin
        we = 1'b1;
        if (sweep_addr_q == sweep_end_q) begin
          out_load = reply_q;
          state_d  = BK_IDLE;
        end else begin
          sweep_addr_d = sweep_addr_q + AW'(1);
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    out_row_d  = out_load ? 5'(row_d) : out_row_q;
    out_col_d  = out_load ? 6'(col_d) : out_col_q;
    out_cell_d = out_load ? out_cell_n : out_cell_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_SWEEP;
      row_q        <= '0;
      col_q        <= '0;
      base_q       <= '0;
      sweep_addr_q <= '0;
      sweep_end_q  <= AW'(CELLS - 1);
      reply_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      base_q       <= base_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
      reply_q      <= reply_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_cell_q <= out_cell_d;
  end

  assign init_busy_o  = (state_q == BK_SWEEP) && !reply_q;
  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cell_data_o  = out_cell_q;

endmodule

`default_nettype wire

/* design/text_terminal_cursor_scroll.sv */
// Top level of the character-cell text terminal with scrolling.
// Instantiates tts_front, tts_queue and tts_back. Uses tts_pkg.
//
// Usage: the input channel (in_valid_i/in_ready_o) carries one word per
// operation: put_char, set_position, clear or read_cell. The output channel
// (out_valid_o/out_ready_i) returns exactly one word per input word, in order,
// holding the cursor position after the operation and, for read_cell, the
// stored character code (zero otherwise).
// The front classifies each word and places it in a two-entry queue; the back
// executes it against the screen store (one write and one registered read
// port). A result passes through the queue and the result register after its
// input word is taken (read_cell also through the registered read).
// Throughput: one word per cycle (receiver ready) for cursor moves, ignored
// codes and printable characters that do not scroll; read_cell passes through
// the BK_READ state in the back for the registered memory read; a scroll blanks
// the bottom row (the screen itself scrolls by a row base offset); clear writes
// one cell per cycle.
// Reset: the store is swept to spaces with in_ready_o low; the cursor homes to
// row 0, column 0.
// A stalled receiver holds the result register; up to two further words are
// taken into the queue before in_ready_o drops.
`default_nettype none

module text_terminal_cursor_scroll #(
  parameter int COLUMNS = tts_pkg::DEF_COLUMNS,
  parameter int ROWS    = tts_pkg::DEF_ROWS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic signed [7:0] row_request_i,
  input  wire logic signed [7:0] col_request_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [4:0]             cursor_row_o,
  output logic [5:0]             cursor_col_o,
  output logic [6:0]             cell_data_o
);
  import tts_pkg::*;

  cmd_t push_cmd, q_cmd;
  logic push, pop, q_full, q_valid, init_busy;

  tts_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .row_request_i(row_request_i),
    .col_request_i(col_request_i),
    .q_full_i     (q_full),
    .init_busy_i  (init_busy),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  tts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .cmd_o  (q_cmd)
  );

  tts_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (q_cmd),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o),
    .cell_data_o (cell_data_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("command popped from empty queue");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_row_o) < ROWS) && (32'(cursor_col_o) < COLUMNS))
    else $error("cursor outside screen");

  a_cell_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cell_data_o != 7'd0) |-> (cell_data_o >= 7'd32) && (cell_data_o != 7'd127))
    else $error("non-printable code read from screen");

  a_no_push_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !push && !pop)
    else $error("command moved during reset sweep");

endmodule

`default_nettype wire
